// ===== hdl/mmce_pkg.sv =====
// shared types, constants and a width-mask function for the multi-mode crc engine
package mmce_pkg;

   // crc variant codes
   localparam logic [1:0] MODE_CRC8      = 2'd0;
   localparam logic [1:0] MODE_CRC16     = 2'd1;
   localparam logic [1:0] MODE_CRC32     = 2'd2;
   localparam logic [1:0] MODE_CRC32_REF = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MODE = 2'd0;
   localparam logic [1:0] CSR_POLY = 2'd1;
   localparam logic [1:0] CSR_INIT = 2'd2;

   localparam logic [31:0] MASK32 = 32'hffff_ffff;
   localparam logic [31:0] MASK16 = 32'h0000_ffff;
   localparam logic [31:0] MASK8  = 32'h0000_00ff;

   localparam logic [1:0] MODE_RESET = MODE_CRC16;

   // settings seen by the byte update logic
   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] poly;
      logic [31:0] init;
   } crc_cfg_type;

   // width mask of a crc variant
   function automatic logic [31:0] width_mask(input logic [1:0] mode);
      logic [31:0] m;
      case (mode)
         MODE_CRC8:  m = MASK8;
         MODE_CRC16: m = MASK16;
         default:    m = MASK32;
      endcase
      return m;
   endfunction

endpackage

// ===== hdl/multi_mode_crc_engine.sv =====
// top level of the multi-mode crc engine: csr, input stage, crc state and result stage
//
//  channel  | direction | payload
//  req_     | in        | tdata: data_byte[7:0]; tuser: start_of_message; tlast: end_of_message
//  rsp_     | out       | tdata: crc_value[31:0]; tlast: crc_final
//  csr_     | in        | wr_en, addr (0 mode, 1 polynomial, 2 init value), wdata[31:0]
//
// one item per cycle while rsp_tready stays high; an item is registered in the input stage and
// then in the result stage, which drives rsp_; the running crc is updated as it leaves the input stage
// the eight-bit update is one xor network between the input stage and the result stage
// synchronous active-high reset clears valids, crc state and csr to reset values
// a stalled result holds; the input stage still takes an item, then req_tready drops
module multi_mode_crc_engine (
   input  logic        clock,
   input  logic        reset,
   // csr write port
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_addr,
   input  logic [31:0] csr_wdata,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_message
   input  logic        req_tlast,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] crc_value
   output logic        rsp_tlast
);

   mmce_pkg::crc_cfg_type cfg_ff, cfg_in;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  in_data_ff, in_data_in;
   logic        in_sop_ff, in_sop_in;
   logic        in_eop_ff, in_eop_in;

   logic        out_vld_ff, out_vld_in;
   logic [31:0] out_crc_ff, out_crc_in;
   logic        out_eop_ff, out_eop_in;

   logic [31:0] crc_ff, crc_in;

   logic        advance;
   logic        req_take;
   logic [31:0] step_next;
   logic [31:0] step_value;

   // csr writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_addr)
            mmce_pkg::CSR_MODE: cfg_in.mode = csr_wdata[1:0];
            mmce_pkg::CSR_POLY: cfg_in.poly = csr_wdata;
            mmce_pkg::CSR_INIT: cfg_in.init = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // handshake: input stage moves on when the result stage is free or draining
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // byte update
   mmce_step u_step (
      .cfg              (cfg_ff),
      .crc_cur          (crc_ff),
      .data_byte        (in_data_ff),
      .start_of_message (in_sop_ff),
      .crc_next         (step_next),
      .crc_value        (step_value)
   );

   // input stage
   always_comb begin
      in_vld_in  = req_take || (in_vld_ff && !advance);
      in_data_in = req_take ? req_tdata : in_data_ff;
      in_sop_in  = req_take ? req_tuser : in_sop_ff;
      in_eop_in  = req_take ? req_tlast : in_eop_ff;
   end

   // crc state and result stage
   always_comb begin
      crc_in     = advance ? step_next : crc_ff;
      out_vld_in = advance || (out_vld_ff && !rsp_tready);
      out_crc_in = advance ? step_value : out_crc_ff;
      out_eop_in = advance ? in_eop_ff : out_eop_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= mmce_pkg::MODE_RESET;
         cfg_ff.poly <= '0;
         cfg_ff.init <= '0;
         crc_ff      <= '0;
         in_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         cfg_ff     <= cfg_in;
         crc_ff     <= crc_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
      in_sop_ff  <= in_sop_in;
      in_eop_ff  <= in_eop_in;
      out_crc_ff <= out_crc_in;
      out_eop_ff <= out_eop_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_crc_ff;
   assign rsp_tlast  = out_eop_ff;

`ifndef SYNTHESIS
   // back-pressure only when the input stage holds an item
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_vld_ff)
      else $error("req_tready low with empty input stage");

   // an item leaving the input stage always lands in the result stage
   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("item lost between stages");

   // an item that cannot move is kept
   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && !advance |=> in_vld_ff)
      else $error("stalled item dropped from input stage");

   // crc8 updates leave the upper state bits clear
   a_crc8_narrow: assert property (@(posedge clock) disable iff (reset)
      advance && cfg_ff.mode == mmce_pkg::MODE_CRC8 |=> crc_ff[31:8] == 24'd0)
      else $error("crc8 state wider than eight bits");
`endif

endmodule

// ===== hdl/mmce_step.sv =====
// one-byte crc update: start load, eight shift steps, output formatting
module mmce_step (
   input  mmce_pkg::crc_cfg_type cfg,
   input  logic [31:0]           crc_cur,
   input  logic [7:0]            data_byte,
   input  logic                  start_of_message,
   output logic [31:0]           crc_next,
   output logic [31:0]           crc_value
);

   logic [31:0] mask;
   logic [31:0] poly;
   logic [31:0] seed;
   logic [31:0] work;
   logic [4:0]  top_bit;

   always_comb begin
      mask = mmce_pkg::width_mask(cfg.mode);
      poly = cfg.poly & mask;

      // load the start value where a message begins
      if (start_of_message) begin
         if (cfg.mode == mmce_pkg::MODE_CRC32_REF) begin
            seed = cfg.init ^ mmce_pkg::MASK32;
         end else begin
            seed = cfg.init & mask;
         end
      end else begin
         seed = crc_cur;
      end

      // top bit position of the active width
      case (cfg.mode)
         mmce_pkg::MODE_CRC8:  top_bit = 5'd7;
         mmce_pkg::MODE_CRC16: top_bit = 5'd15;
         default:              top_bit = 5'd31;
      endcase

      work = seed & mask;
      if (cfg.mode == mmce_pkg::MODE_CRC32_REF) begin
         // reflected: byte enters at the bottom, shift right
         work = work ^ {24'd0, data_byte};
         for (int i = 0; i < 8; i++) begin
            if (work[0]) begin
               work = (work >> 1) ^ poly;
            end else begin
               work = work >> 1;
            end
         end
      end else begin
         // msb first: byte enters with its msb at the top bit, shift left
         work = work ^ (({24'd0, data_byte} << (top_bit - 5'd7)) & mask);
         for (int i = 0; i < 8; i++) begin
            if (work[top_bit]) begin
               work = ((work << 1) ^ poly) & mask;
            end else begin
               work = (work << 1) & mask;
            end
         end
      end

      crc_next = work;
      if (cfg.mode == mmce_pkg::MODE_CRC32_REF) begin
         crc_value = work ^ mmce_pkg::MASK32;
      end else begin
         crc_value = work & mask;
      end
   end

endmodule

// ===== tb/multi_mode_crc_engine_test.sv =====
// self-checking testbench for the multi-mode crc engine: directed and random byte streams
module multi_mode_crc_engine_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD = 8;
   // no register sits at this index, writes to it are ignored
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [31:0] crc_value;
      logic        crc_final;
   } crc_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_addr = '0;
   logic [31:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   // model of the engine's settings and running crc
   logic [1:0]  cfg_mode = mmce_pkg::MODE_RESET;
   logic [31:0] cfg_poly = '0;
   logic [31:0] cfg_init = '0;
   logic [31:0] running_crc = '0;

   crc_result_type pending_crc[$];
   int          error_count = 0;
   int          bytes_sent = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;

   multi_mode_crc_engine dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // crc width of each variant
   function automatic logic [31:0] mode_width_mask(input logic [1:0] mode);
      case (mode)
         mmce_pkg::MODE_CRC8:  return 32'h0000_00ff;
         mmce_pkg::MODE_CRC16: return 32'h0000_ffff;
         default:              return 32'hffff_ffff;
      endcase
   endfunction

   // eight bit-serial shift steps of one message byte
   function automatic logic [31:0] crc_after_byte(input logic [1:0] mode, input logic [31:0] poly,
                                                  input logic [31:0] crc_in, input logic [7:0] b);
      logic [31:0] m;
      logic [31:0] p;
      logic [31:0] r;
      logic [31:0] top;
      int          i;
      m = mode_width_mask(mode);
      p = poly & m;
      r = crc_in & m;
      if (mode == mmce_pkg::MODE_CRC32_REF) begin
         r = r ^ {24'd0, b};
         for (i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ p) : (r >> 1);
         return r;
      end
      case (mode)
         mmce_pkg::MODE_CRC8: begin
            top = 32'h0000_0080;
            r = r ^ {24'd0, b};
         end
         mmce_pkg::MODE_CRC16: begin
            top = 32'h0000_8000;
            r = r ^ {16'd0, b, 8'd0};
         end
         default: begin
            top = 32'h8000_0000;
            r = r ^ {b, 24'd0};
         end
      endcase
      for (i = 0; i < 8; i++)
         r = ((r & top) != 0) ? (((r << 1) ^ p) & m) : ((r << 1) & m);
      return r;
   endfunction

   // extremes now and then, otherwise any word
   function automatic logic [31:0] random_word();
      case ($urandom_range(7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // receiver stalls
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // compare each result with the oldest predicted crc
   always @(posedge clock) begin : check_result
      crc_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_crc.size() == 0) begin
            $error("unexpected result: crc_value %h crc_final %b", rsp_tdata, rsp_tlast);
            error_count++;
         end else begin
            want = pending_crc.pop_front();
            if (rsp_tdata !== want.crc_value) begin
               $error("crc_value mismatch: expected %h actual %h", want.crc_value, rsp_tdata);
               error_count++;
            end
            if (rsp_tlast !== want.crc_final) begin
               $error("crc_final mismatch: expected %b actual %b", want.crc_final, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // present one item, wait for acceptance and predict its crc
   task automatic send_byte(input logic [7:0] b, input logic sop, input logic eop);
      crc_result_type r;
      logic [31:0] m;
      @(negedge clock);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= sop;
      req_tlast  <= eop;
      do @(posedge clock); while (!req_tready);
      m = mode_width_mask(cfg_mode);
      if (sop)
         running_crc = (cfg_mode == mmce_pkg::MODE_CRC32_REF) ?
                       (cfg_init ^ mmce_pkg::MASK32) : (cfg_init & m);
      running_crc = crc_after_byte(cfg_mode, cfg_poly, running_crc, b);
      r.crc_value = (cfg_mode == mmce_pkg::MODE_CRC32_REF) ?
                    (running_crc ^ mmce_pkg::MASK32) : (running_crc & m);
      r.crc_final = eop;
      pending_crc.push_back(r);
      bytes_sent++;
   endtask

   // stop sending and let every outstanding result arrive
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_crc.size() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   // register write while the engine is idle
   task automatic write_csr(input logic [1:0] addr, input logic [31:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (addr)
         mmce_pkg::CSR_MODE: cfg_mode = value[1:0];
         mmce_pkg::CSR_POLY: cfg_poly = value;
         mmce_pkg::CSR_INIT: cfg_init = value;
         default: ;
      endcase
   endtask

   // reset values: crc16, zero polynomial, no start flag so the cleared register is used
   task automatic test_reset_state();
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
   endtask

   // crc8 uses only the low polynomial byte
   task automatic test_crc8();
      write_csr(mmce_pkg::CSR_MODE, {30'd0, mmce_pkg::MODE_CRC8});
      write_csr(mmce_pkg::CSR_POLY, 32'hffff_ff07);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h5a, 1'b0, 1'b1);
   endtask

   // crc16 with all-ones start value masked to sixteen bits
   task automatic test_crc16();
      write_csr(mmce_pkg::CSR_MODE, {30'd0, mmce_pkg::MODE_CRC16});
      write_csr(mmce_pkg::CSR_POLY, 32'h0000_1021);
      write_csr(mmce_pkg::CSR_INIT, 32'hffff_ffff);
      send_byte(8'h31, 1'b1, 1'b0);
      send_byte(8'h32, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b1);
   endtask

   // crc32 shifted msb first
   task automatic test_crc32();
      write_csr(mmce_pkg::CSR_MODE, {30'd0, mmce_pkg::MODE_CRC32});
      write_csr(mmce_pkg::CSR_POLY, 32'h04c1_1db7);
      send_byte(8'h80, 1'b1, 1'b0);
      send_byte(8'h01, 1'b0, 1'b0);
      send_byte(8'hff, 1'b0, 1'b0);
      send_byte(8'h00, 1'b0, 1'b1);
   endtask

   // reflected crc32 with inverted start and output, then a one-byte message
   task automatic test_crc32_reflected();
      write_csr(mmce_pkg::CSR_MODE, {30'd0, mmce_pkg::MODE_CRC32_REF});
      write_csr(mmce_pkg::CSR_POLY, 32'hedb8_8320);
      write_csr(mmce_pkg::CSR_INIT, 32'h0000_0000);
      send_byte(8'h31, 1'b1, 1'b0);
      send_byte(8'h32, 1'b0, 1'b0);
      send_byte(8'h33, 1'b0, 1'b0);
      send_byte(8'h34, 1'b0, 1'b1);
      write_csr(mmce_pkg::CSR_INIT, 32'hffff_ffff);
      send_byte(8'ha5, 1'b1, 1'b1);
   endtask

   // mode switched inside a message, plus a write to the unused index
   task automatic test_mode_change_in_message();
      write_csr(mmce_pkg::CSR_MODE, {30'd0, mmce_pkg::MODE_CRC32});
      write_csr(mmce_pkg::CSR_POLY, 32'hffff_ffff);
      send_byte(8'h3c, 1'b1, 1'b0);
      write_csr(CSR_UNUSED, 32'hffff_ffff);
      write_csr(mmce_pkg::CSR_MODE, 32'hffff_fffc);
      send_byte(8'hff, 1'b0, 1'b1);
   endtask

   // random messages under one idling pattern, settings changed between messages and now and then the mode inside one
   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
      int target;
      int len;
      int i;
      target = bytes_sent + n_items;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      while (bytes_sent < target) begin
         if ($urandom_range(3) == 0) begin
            write_csr(mmce_pkg::CSR_MODE, $urandom);
            write_csr(mmce_pkg::CSR_POLY, random_word());
            write_csr(mmce_pkg::CSR_INIT, random_word());
         end
         if ($urandom_range(99) < 85) begin
            // well-formed message
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) begin
               if (i == 1 && $urandom_range(19) == 0)
                  write_csr(mmce_pkg::CSR_MODE, $urandom);
               send_byte(8'($urandom_range(255)), i == 0, i == len - 1);
            end
         end else begin
            // loose flags
            len = $urandom_range(1, 6);
            for (i = 0; i < len; i++)
               send_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                         1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_crc8();
      test_crc16();
      test_crc32();
      test_crc32_reflected();
      test_mode_change_in_message();
      test_random_traffic(0, 0, 285);
      test_random_traffic(61, 0, 285);
      test_random_traffic(0, 61, 285);
      test_random_traffic(23, 23, 285);
      drain();
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
